// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RTPH_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define RTPH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rtph_pkg.sv -----
`default_nettype none
package rtph_pkg;

  localparam int COORD_BITS = 21;
  localparam int FRAC_BITS  = 10;
  localparam int PACK_BITS  = 63;
  localparam int DIST_BITS  = 32;
  localparam int DIST_FRAC  = 16;
  localparam int EPS_BITS   = 40;
  localparam int NRM_OUT    = 43;
  localparam int MAG_BITS   = 64;

  localparam int LB    = COORD_BITS + 1;
  localparam int NW    = 2 * COORD_BITS + 1;
  localparam int VW    = 2 * COORD_BITS + 2;
  localparam int PLW   = 2 * COORD_BITS + 3;
  localparam int PHW   = 2 * COORD_BITS + 2;
  localparam int SW    = 3 * COORD_BITS + 5;
  localparam int SW1   = SW + 1;
  localparam int NUM_SHIFT = DIST_BITS - DIST_FRAC;

  localparam int FSTAGES  = 7;
  localparam int QDEPTH   = 4;
  localparam int PTR_BITS = $clog2(QDEPTH);
  localparam int CNT_BITS = $clog2(QDEPTH + 1);

  localparam logic [DIST_BITS-1:0] MIN_DIST_RST = DIST_BITS'(66);
  localparam logic [EPS_BITS-1:0]  EPS_RST      = EPS_BITS'(10737);

  typedef enum logic {
    REG_MIN_DIST = 1'b0,
    REG_EPS      = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                           miss;
    logic [MAG_BITS-1:0]            den;
    logic [MAG_BITS-1:0]            num;
    logic [2:0][NW-1:0]             nrm;
    logic [2:0][COORD_BITS-1:0]     rd;
  } q_t;

  typedef struct packed {
    logic                           miss;
    logic                           sat;
    logic [MAG_BITS-1:0]            rem;
    logic [MAG_BITS-1:0]            den;
    logic [NUM_SHIFT-1:0]           nlo;
    logic [DIST_BITS-1:0]           q;
    logic [2:0][NW-1:0]             nrm;
    logic [2:0][COORD_BITS-1:0]     rd;
  } dv_t;

endpackage
`default_nettype wire

// ----- design/rtph_ifs.sv -----
`default_nettype none
interface rtph_in_if import rtph_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [PACK_BITS-1:0] ray_origin;
  logic [PACK_BITS-1:0] ray_dir;
  logic [PACK_BITS-1:0] shape_origin;
  logic [PACK_BITS-1:0] edge_a;
  logic [PACK_BITS-1:0] edge_b;

  modport source (output valid, op, ray_origin, ray_dir, shape_origin, edge_a, edge_b,
                  input ready);
  modport sink   (input valid, op, ray_origin, ray_dir, shape_origin, edge_a, edge_b,
                  output ready);
endinterface

interface rtph_out_if import rtph_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [DIST_BITS-1:0]       distance;
  logic signed [NRM_OUT-1:0]  normal_x;
  logic signed [NRM_OUT-1:0]  normal_y;
  logic signed [NRM_OUT-1:0]  normal_z;

  modport source (output valid, hit, distance, normal_x, normal_y, normal_z, input ready);
  modport sink   (input valid, hit, distance, normal_x, normal_y, normal_z, output ready);
endinterface
`default_nettype wire

// ----- design/rtph_fifo.sv -----
`default_nettype none
`include "assert_macros.svh"
module rtph_fifo import rtph_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  q_t   wdata,
  output logic full,
  input  logic pop,
  output q_t   rdata,
  output logic nempty
);

  q_t                  mem_r [QDEPTH];
  logic [PTR_BITS-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r + PTR_BITS'(push);
    rp_nxt  = rp_r + PTR_BITS'(pop);
    cnt_nxt = cnt_r + CNT_BITS'(push) - CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  assign rdata  = mem_r[rp_r];
  assign full   = (cnt_r == CNT_BITS'(QDEPTH));
  assign nempty = (cnt_r != '0);

  `RTPH_ASSERT_IMPL(a_no_overflow, push, cnt_r != CNT_BITS'(QDEPTH), "push into full queue")
  `RTPH_ASSERT_IMPL(a_no_underflow, pop, cnt_r != '0, "pop from empty queue")
  `RTPH_ASSERT_NEXT(a_count_up, push && !pop, cnt_r == $past(cnt_r) + CNT_BITS'(1),
                    "queue count lost a transaction")

endmodule
`default_nettype wire

// ----- design/rtph_front.sv -----
`default_nettype none
module rtph_front import rtph_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  rtph_in_if.sink             in_ch,
  input  logic [EPS_BITS-1:0] eps,
  output logic                push,
  output q_t                  qd,
  input  logic                full
);

  localparam int CB = COORD_BITS;

  logic               en;
  logic [FSTAGES:1]   vld_r;

  logic signed [CB-1:0] ro [3], rd [3], so [3], ea [3], eb [3];

  // stage 1
  logic                   op1_r;
  logic signed [LB-1:0]   oc1_nxt [3], oc1_r [3];
  logic signed [CB-1:0]   rd1_r [3], ea1_r [3], eb1_r [3];
  logic signed [2*CB-1:0] na1_nxt [3], nb1_nxt [3], na1_r [3], nb1_r [3];
  logic signed [NW-1:0]   va1_nxt [3], vb1_nxt [3], va1_r [3], vb1_r [3];
  // stage 2
  logic                   op2_r;
  logic signed [NW-1:0]   nrm2_nxt [3], nrm2_r [3];
  logic signed [VW-1:0]   vp2_nxt [3], vp2_r [3];
  logic signed [CB-1:0]   rd2_r [3], ea2_r [3], eb2_r [3];
  logic signed [LB-1:0]   oc2_r [3];
  // stage 3
  logic                   op3_r;
  logic signed [LB-1:0]   ax [4][3];
  logic signed [VW-1:0]   xx [4][3];
  logic signed [PLW-1:0]  pl3_nxt [4][3], pl3_r [4][3];
  logic signed [PHW-1:0]  ph3_nxt [4][3], ph3_r [4][3];
  logic signed [NW-1:0]   nrm3_r [3];
  logic signed [CB-1:0]   rd3_r [3];
  // stage 4
  logic                   op4_r;
  logic signed [SW-1:0]   t4_nxt [4][3], t4_r [4][3];
  logic signed [NW-1:0]   nrm4_r [3];
  logic signed [CB-1:0]   rd4_r [3];
  // stage 5
  logic                   op5_r;
  logic signed [SW-1:0]   s5_nxt [4], s5_r [4];
  logic signed [NW-1:0]   nrm5_r [3];
  logic signed [CB-1:0]   rd5_r [3];
  // stage 6
  logic                   op6_r, zero6_nxt, zero6_r, neg6;
  logic signed [SW-1:0]   den6_nxt, b6_nxt, c6_nxt, tn6_nxt;
  logic signed [SW-1:0]   den6_r, b6_r, c6_r, tn6_r;
  logic signed [NW-1:0]   nrm6_r [3];
  logic signed [CB-1:0]   rd6_r [3];
  // stage 7
  logic                   miss7_nxt, over7;
  logic signed [SW1-1:0]  bc7;
  q_t                     q7_nxt, q7_r;

  assign en          = !(vld_r[FSTAGES] && full);
  assign push        = vld_r[FSTAGES] && !full;
  assign in_ch.ready = en;
  assign qd          = q7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[FSTAGES-1:1], in_ch.valid};
    end
  end

  genvar g, d;
  for (g = 0; g < 3; g++) begin : g_s1
    localparam int J = (g + 1) % 3;
    localparam int K = (g + 2) % 3;
    assign ro[g] = $signed(in_ch.ray_origin[g*CB +: CB]);
    assign rd[g] = $signed(in_ch.ray_dir[g*CB +: CB]);
    assign so[g] = $signed(in_ch.shape_origin[g*CB +: CB]);
    assign ea[g] = $signed(in_ch.edge_a[g*CB +: CB]);
    assign eb[g] = $signed(in_ch.edge_b[g*CB +: CB]);
    assign oc1_nxt[g] = LB'(so[g]) - LB'(ro[g]);
    assign na1_nxt[g] = ea[J] * eb[K];
    assign nb1_nxt[g] = ea[K] * eb[J];
    assign va1_nxt[g] = oc1_nxt[J] * rd[K];
    assign vb1_nxt[g] = oc1_nxt[K] * rd[J];
    assign nrm2_nxt[g] = NW'(na1_r[g]) - NW'(nb1_r[g]);
    assign vp2_nxt[g]  = VW'(va1_r[g]) - VW'(vb1_r[g]);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ax[0][i] = LB'(rd2_r[i]);
      xx[0][i] = VW'(nrm2_r[i]);
      ax[1][i] = LB'(ea2_r[i]);
      xx[1][i] = vp2_r[i];
      ax[2][i] = LB'(eb2_r[i]);
      xx[2][i] = vp2_r[i];
      ax[3][i] = oc2_r[i];
      xx[3][i] = VW'(nrm2_r[i]);
    end
  end

  for (d = 0; d < 4; d++) begin : g_dot
    for (g = 0; g < 3; g++) begin : g_term
      assign pl3_nxt[d][g] = ax[d][g] * $signed({1'b0, xx[d][g][LB-1:0]});
      assign ph3_nxt[d][g] = ax[d][g] * $signed(xx[d][g][VW-1:LB]);
      assign t4_nxt[d][g]  = (SW'(ph3_r[d][g]) <<< LB) + SW'(pl3_r[d][g]);
    end
    assign s5_nxt[d] = t4_r[d][0] + t4_r[d][1] + t4_r[d][2];
  end

  always_comb begin
    neg6      = s5_r[0][SW-1];
    zero6_nxt = (s5_r[0] == '0);
    den6_nxt  = neg6 ? -s5_r[0] : s5_r[0];
    b6_nxt    = neg6 ? -s5_r[1] : s5_r[1];
    c6_nxt    = neg6 ? s5_r[2] : -s5_r[2];
    tn6_nxt   = neg6 ? -s5_r[3] : s5_r[3];
  end

  always_comb begin
    bc7 = SW1'(b6_r) + SW1'(c6_r);
    if (op6_r) begin
      over7 = (b6_r > den6_r) || (c6_r > den6_r);
    end else begin
      over7 = (bc7 > SW1'(den6_r));
    end
    miss7_nxt = zero6_r || (den6_r[MAG_BITS-1:0] < MAG_BITS'(eps))
             || b6_r[SW-1] || c6_r[SW-1] || tn6_r[SW-1] || over7;
    q7_nxt.miss = miss7_nxt;
    q7_nxt.den  = den6_r[MAG_BITS-1:0];
    q7_nxt.num  = tn6_r[MAG_BITS-1:0];
    for (int i = 0; i < 3; i++) begin
      q7_nxt.nrm[i] = nrm6_r[i];
      q7_nxt.rd[i]  = rd6_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= in_ch.op;
      op2_r <= op1_r;
      op3_r <= op2_r;
      op4_r <= op3_r;
      op5_r <= op4_r;
      op6_r <= op5_r;
      for (int i = 0; i < 3; i++) begin
        rd1_r[i]  <= rd[i];
        ea1_r[i]  <= ea[i];
        eb1_r[i]  <= eb[i];
        oc1_r[i]  <= oc1_nxt[i];
        na1_r[i]  <= na1_nxt[i];
        nb1_r[i]  <= nb1_nxt[i];
        va1_r[i]  <= va1_nxt[i];
        vb1_r[i]  <= vb1_nxt[i];
        nrm2_r[i] <= nrm2_nxt[i];
        vp2_r[i]  <= vp2_nxt[i];
        rd2_r[i]  <= rd1_r[i];
        ea2_r[i]  <= ea1_r[i];
        eb2_r[i]  <= eb1_r[i];
        oc2_r[i]  <= oc1_r[i];
        nrm3_r[i] <= nrm2_r[i];
        rd3_r[i]  <= rd2_r[i];
        nrm4_r[i] <= nrm3_r[i];
        rd4_r[i]  <= rd3_r[i];
        nrm5_r[i] <= nrm4_r[i];
        rd5_r[i]  <= rd4_r[i];
        nrm6_r[i] <= nrm5_r[i];
        rd6_r[i]  <= rd5_r[i];
      end
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          pl3_r[k][i] <= pl3_nxt[k][i];
          ph3_r[k][i] <= ph3_nxt[k][i];
          t4_r[k][i]  <= t4_nxt[k][i];
        end
        s5_r[k] <= s5_nxt[k];
      end
      zero6_r <= zero6_nxt;
      den6_r  <= den6_nxt;
      b6_r    <= b6_nxt;
      c6_r    <= c6_nxt;
      tn6_r   <= tn6_nxt;
      q7_r    <= q7_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/rtph_back.sv -----
`default_nettype none
module rtph_back import rtph_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 nempty,
  input  q_t                   qd,
  output logic                 pop,
  input  logic [DIST_BITS-1:0] min_dist,
  rtph_out_if.source           out_ch
);

  localparam int NDIV = DIST_BITS;

  logic                       adv;
  logic [NDIV:0]              vld_r;
  dv_t                        dv_r [NDIV+1];
  dv_t                        dv0_nxt;
  dv_t                        dvs_nxt [NDIV+1];
  logic                       out_vld_r;
  logic                       hit_nxt, hit_r;
  logic [DIST_BITS-1:0]       dist_full, dist_nxt, dist_r;
  logic signed [NRM_OUT-1:0]  nrm_nxt [3], nrm_o_r [3];

  function automatic dv_t div_step(dv_t dv);
    dv_t                 r;
    logic [MAG_BITS:0]   sh;
    logic                ge;
    r  = dv;
    sh = {dv.rem, dv.nlo[NUM_SHIFT-1]};
    ge = (sh >= {1'b0, dv.den});
    r.nlo = dv.nlo << 1;
    r.rem = ge ? (sh[MAG_BITS-1:0] - dv.den) : sh[MAG_BITS-1:0];
    r.q   = {dv.q[DIST_BITS-2:0], ge};
    return r;
  endfunction

  assign adv = !out_vld_r || out_ch.ready;
  assign pop = adv && nempty;

  always_comb begin
    dv0_nxt.miss = qd.miss;
    dv0_nxt.sat  = (MAG_BITS'(qd.num[MAG_BITS-1:NUM_SHIFT]) >= qd.den);
    dv0_nxt.rem  = MAG_BITS'(qd.num[MAG_BITS-1:NUM_SHIFT]);
    dv0_nxt.den  = qd.den;
    dv0_nxt.nlo  = qd.num[NUM_SHIFT-1:0];
    dv0_nxt.q    = '0;
    dv0_nxt.nrm  = qd.nrm;
    dv0_nxt.rd   = qd.rd;
    dvs_nxt[0]   = dv0_nxt;
    for (int k = 1; k <= NDIV; k++) begin
      dvs_nxt[k] = div_step(dv_r[k-1]);
    end
  end

  always_comb begin
    dist_full = dv_r[NDIV].sat ? '1 : dv_r[NDIV].q;
    hit_nxt   = !dv_r[NDIV].miss && (dist_full > min_dist);
    dist_nxt  = hit_nxt ? dist_full : '0;
    for (int i = 0; i < 3; i++) begin
      if (hit_nxt) begin
        nrm_nxt[i] = NRM_OUT'($signed(dv_r[NDIV].nrm[i]));
      end else begin
        nrm_nxt[i] = NRM_OUT'($signed({dv_r[NDIV].rd[i], {FRAC_BITS{1'b0}}}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= {vld_r[NDIV-1:0], nempty};
      out_vld_r <= vld_r[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= NDIV; k++) begin
        dv_r[k] <= dvs_nxt[k];
      end
      hit_r  <= hit_nxt;
      dist_r <= dist_nxt;
      for (int i = 0; i < 3; i++) begin
        nrm_o_r[i] <= nrm_nxt[i];
      end
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.hit      = hit_r;
  assign out_ch.distance = dist_r;
  assign out_ch.normal_x = nrm_o_r[0];
  assign out_ch.normal_y = nrm_o_r[1];
  assign out_ch.normal_z = nrm_o_r[2];

endmodule
`default_nettype wire

// ----- design/ray_triangle_parallelogram_hit_unit.sv -----
// Throughput: one transaction per cycle while the output is not stalled; the divider is a
// 32-stage pipeline, one quotient bit per stage, fed from a 4-entry queue behind a 7-stage
// arithmetic front.
// Reset: synchronous, active low; clears all valid flags and queue pointers and loads
// min_distance = 66 and parallel_epsilon = 10737. No clearing pass.
`default_nettype none
`include "assert_macros.svh"
module ray_triangle_parallelogram_hit_unit import rtph_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rtph_in_if.sink     in_ch,
  rtph_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [DIST_BITS-1:0] min_dist_r;
  logic [EPS_BITS-1:0]  eps_r;
  logic                 wr_en;
  reg_idx_t             idx;
  logic                 push, full, pop, nempty;
  q_t                   qw, qr;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r <= MIN_DIST_RST;
      eps_r      <= EPS_RST;
    end else if (wr_en) begin
      case (idx)
        REG_MIN_DIST: min_dist_r <= pwdata[DIST_BITS-1:0];
        REG_EPS:      eps_r      <= pwdata[EPS_BITS-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2:0] == 3'b000) begin
      case (idx)
        REG_MIN_DIST: prdata = 64'(min_dist_r);
        REG_EPS:      prdata = 64'(eps_r);
        default:      prdata = '0;
      endcase
    end
  end

  rtph_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .eps   (eps_r),
    .push  (push),
    .qd    (qw),
    .full  (full)
  );

  rtph_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wdata  (qw),
    .full   (full),
    .pop    (pop),
    .rdata  (qr),
    .nempty (nempty)
  );

  rtph_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .nempty   (nempty),
    .qd       (qr),
    .pop      (pop),
    .min_dist (min_dist_r),
    .out_ch   (out_ch)
  );

  `RTPH_ASSERT_IMPL(a_hit_beyond_min, out_ch.valid && out_ch.hit,
                    out_ch.distance > min_dist_r, "hit at or below minimum distance")

endmodule
`default_nettype wire
